// File: design/tdrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the task delay/ready scheduler.
// No dependencies; used by every module of the block.
package tdrs_pkg;

    localparam int TASK_COUNT = 8;
    localparam int CMD_W      = 3;
    localparam int REQ_W      = 3;
    localparam int DLY_W      = 16;
    localparam int SEL_OUT_W  = 4;
    // internal index wide enough to hold the idle index TASK_COUNT
    localparam int IDX_W      = $clog2(TASK_COUNT + 1);
    localparam logic [IDX_W-1:0] IDLE_IDX = IDX_W'(TASK_COUNT);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_DELAY  = 3'd1,
        CMD_READY  = 3'd2,
        CMD_CREATE = 3'd3,
        CMD_SCHED  = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_READY  = 2'd1,
        ST_ACTIVE = 2'd2,
        ST_WAIT   = 2'd3
    } status_e;

    // per-cell strobes, at most one set per cycle
    typedef struct packed {
        logic tick;
        logic load_delay;
        logic set_ready;
        logic create;
        logic sched;
    } cell_cmd_t;

endpackage

// File: design/tdrs_cell.sv
`timescale 1ns / 1ps
// One task cell: status and delay counter plus one link of the priority chain.
// Depends on tdrs_pkg.
module tdrs_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdrs_pkg::cell_cmd_t           cmd,
    input  logic [tdrs_pkg::DLY_W-1:0]    delay_ms,
    input  logic [tdrs_pkg::IDX_W-1:0]    cell_idx,
    input  logic                          claim_in,
    input  logic [tdrs_pkg::IDX_W-1:0]    sel_in,
    output logic                          claim_out,
    output logic [tdrs_pkg::IDX_W-1:0]    sel_out
);

    tdrs_pkg::status_e              status_reg, status_next;
    logic [tdrs_pkg::DLY_W-1:0]     count_reg, count_next;
    logic                           is_ready;
    logic                           win;

    assign is_ready  = (status_reg == tdrs_pkg::ST_READY);
    assign win       = is_ready && !claim_in;
    assign claim_out = claim_in || is_ready;
    assign sel_out   = win ? cell_idx : sel_in;

    always_comb
    begin
        status_next = status_reg;
        count_next  = count_reg;
        if (cmd.tick && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
            if (count_reg == tdrs_pkg::DLY_W'(1))
            begin
                status_next = tdrs_pkg::ST_READY;
            end
        end
        if (cmd.load_delay)
        begin
            count_next  = delay_ms;
            status_next = tdrs_pkg::ST_WAIT;
        end
        if (cmd.set_ready)
        begin
            status_next = tdrs_pkg::ST_READY;
        end
        if (cmd.create)
        begin
            count_next  = '0;
            status_next = tdrs_pkg::ST_READY;
        end
        if (cmd.sched && win)
        begin
            status_next = tdrs_pkg::ST_ACTIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= tdrs_pkg::ST_NONE;
            count_reg  <= '0;
        end
        else
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/task_delay_ready_scheduler_unit.sv
`timescale 1ns / 1ps
// Top level of the task scheduler: command decode, row of task cells, result register.
// Depends on tdrs_pkg and tdrs_cell.
//
// Fixed-priority scheduler for TASK_COUNT tasks (8). Every accepted input
// word is one command: tick, delay, ready, create or schedule; each gives
// exactly one result word (selected_task, found). The task cells update at
// the accepting edge and the result is registered there, so out_valid rises
// on the next cycle and one command per cycle is sustained while out_stall
// is low. Throughput is set by the single result register: in_stall is
// high only while a result is held by out_stall. Schedule walks a ripple
// priority chain through the cells, lowest index first; the first ready task
// becomes active and its index is returned with found = 1. With no ready
// task, and for every other command, selected_task shows the idle index 8
// with found = 0. Delay/ready/create with a task index of TASK_COUNT or more
// are ignored, as are command codes 5 to 7. Reset clears cells and out_valid only.
module task_delay_ready_scheduler_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tdrs_pkg::CMD_W-1:0]        command,
    input  logic [tdrs_pkg::REQ_W-1:0]        task_req,
    input  logic [tdrs_pkg::DLY_W-1:0]        delay_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdrs_pkg::SEL_OUT_W-1:0]    selected_task,
    output logic                              found
);

    localparam int N = tdrs_pkg::TASK_COUNT;

    logic                           accept;
    logic                           req_ok;
    logic                           do_tick, do_delay, do_ready, do_create, do_sched;
    tdrs_pkg::cell_cmd_t            cell_cmd [N];
    logic [N:0]                     claim;
    logic [tdrs_pkg::IDX_W-1:0]     sel [N+1];

    logic                           out_valid_reg, out_valid_next;
    logic [tdrs_pkg::IDX_W-1:0]     sel_reg, sel_next;
    logic                           found_reg, found_next;

    // single output register: stall input only while its word is held
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign req_ok   = (32'(task_req) < N);

    // command decode
    always_comb
    begin
        do_tick   = 1'b0;
        do_delay  = 1'b0;
        do_ready  = 1'b0;
        do_create = 1'b0;
        do_sched  = 1'b0;
        unique case (tdrs_pkg::cmd_e'(command))
            tdrs_pkg::CMD_TICK:   do_tick   = accept;
            tdrs_pkg::CMD_DELAY:  do_delay  = accept && req_ok;
            tdrs_pkg::CMD_READY:  do_ready  = accept && req_ok;
            tdrs_pkg::CMD_CREATE: do_create = accept && req_ok;
            tdrs_pkg::CMD_SCHED:  do_sched  = accept;
            default: ;
        endcase
    end

    // chain head: nothing claimed yet, idle index
    assign claim[0] = 1'b0;
    assign sel[0]   = tdrs_pkg::IDLE_IDX;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic hit;
        assign hit = (32'(task_req) == i);

        always_comb
        begin
            cell_cmd[i].tick       = do_tick;
            cell_cmd[i].load_delay = do_delay  && hit;
            cell_cmd[i].set_ready  = do_ready  && hit;
            cell_cmd[i].create     = do_create && hit;
            cell_cmd[i].sched      = do_sched;
        end

        tdrs_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd[i]),
            .delay_ms  (delay_ms),
            .cell_idx  (tdrs_pkg::IDX_W'(i)),
            .claim_in  (claim[i]),
            .sel_in    (sel[i]),
            .claim_out (claim[i+1]),
            .sel_out   (sel[i+1])
        );
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        sel_next       = sel_reg;
        found_next     = found_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            found_next     = do_sched && claim[N];
            sel_next       = do_sched ? sel[N] : tdrs_pkg::IDLE_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg   <= sel_next;
        found_reg <= found_next;
    end

    assign out_valid     = out_valid_reg;
    assign selected_task = tdrs_pkg::SEL_OUT_W'(sel_reg);
    assign found         = found_reg;

endmodule

// File: design/tdrs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the task scheduler, bound to the top level.
// Depends on tdrs_pkg and task_delay_ready_scheduler_unit.
module tdrs_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [tdrs_pkg::SEL_OUT_W-1:0]    selected_task,
    input logic                              found
);

    localparam logic [tdrs_pkg::SEL_OUT_W-1:0] IDLE_SEL =
        tdrs_pkg::SEL_OUT_W'(tdrs_pkg::TASK_COUNT);

    // held result word stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // every accepted command yields a result word on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted command gave no result word");

    // input only back-pressured by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // found pairs with a real task index, not found with the idle index
    a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found && (32'(selected_task) < tdrs_pkg::TASK_COUNT))
                   || (!found && (selected_task == IDLE_SEL)))
        else $error("found flag and task index disagree");

endmodule

bind task_delay_ready_scheduler_unit tdrs_checker u_tdrs_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for task_delay_ready_scheduler_unit: directed and random command words.
// Depends on tdrs_pkg and the scheduler RTL; keeps its own copy of task states and tick counters.
module tb_top;

    // generous limit on the length of the whole run
    localparam int unsigned CYCLE_LIMIT = 200000;

    // command codes the block does not use
    localparam logic [tdrs_pkg::CMD_W-1:0]     CMD_SPARE_FIRST = 3'd5;
    localparam logic [tdrs_pkg::CMD_W-1:0]     CMD_SPARE_LAST  = 3'd7;
    localparam logic [tdrs_pkg::SEL_OUT_W-1:0] IDLE_SEL        =
        tdrs_pkg::SEL_OUT_W'(tdrs_pkg::TASK_COUNT);
    localparam logic [tdrs_pkg::DLY_W-1:0]     DLY_MAX         = '1;

    typedef struct packed {
        logic [tdrs_pkg::SEL_OUT_W-1:0] sel;
        logic                           hit;
    } pick_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [tdrs_pkg::CMD_W-1:0]     command   = '0;
    logic [tdrs_pkg::REQ_W-1:0]     task_req  = '0;
    logic [tdrs_pkg::DLY_W-1:0]     delay_ms  = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [tdrs_pkg::SEL_OUT_W-1:0] selected_task;
    logic                           found;

    // idle / stall odds in percent, changed per phase
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    // long receiver hold-off: requested at a rising edge, served by the stall process
    int unsigned hold_req  = 0;
    int unsigned hold_left = 0;

    int unsigned cycles      = 0;
    int unsigned err_count   = 0;
    int unsigned words_in    = 0;
    int unsigned words_out   = 0;
    int unsigned picks_found = 0;
    int unsigned cmd_seen [8];

    // scheduler state as predicted from accepted words
    tdrs_pkg::status_e          task_state [tdrs_pkg::TASK_COUNT];
    logic [tdrs_pkg::DLY_W-1:0] tick_left  [tdrs_pkg::TASK_COUNT];
    // results still owed by the block, oldest first
    pick_t                      pending_picks [$];

    task_delay_ready_scheduler_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .task_req      (task_req),
        .delay_ms      (delay_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .selected_task (selected_task),
        .found         (found)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one command word to the predicted state and return the result
    // word it should produce. Tick counts every nonzero counter down and
    // readies a task whose counter lands on zero, whatever its status.
    // Schedule takes the lowest ready task and makes it active.
    function automatic pick_t predict_command(input logic [tdrs_pkg::CMD_W-1:0] c,
                                              input logic [tdrs_pkg::REQ_W-1:0] t,
                                              input logic [tdrs_pkg::DLY_W-1:0] d);
        pick_t r;
        bit    in_range;
        r.sel    = IDLE_SEL;
        r.hit    = 1'b0;
        in_range = int'(t) < tdrs_pkg::TASK_COUNT;
        case (c)
            tdrs_pkg::CMD_TICK:
            begin
                for (int i = 0; i < tdrs_pkg::TASK_COUNT; i++)
                begin
                    if (tick_left[i] != '0)
                    begin
                        tick_left[i] = tick_left[i] - 1'b1;
                        if (tick_left[i] == '0)
                            task_state[i] = tdrs_pkg::ST_READY;
                    end
                end
            end
            tdrs_pkg::CMD_DELAY:
            begin
                if (in_range)
                begin
                    tick_left[t]  = d;
                    task_state[t] = tdrs_pkg::ST_WAIT;
                end
            end
            tdrs_pkg::CMD_READY:
            begin
                // counter is kept, so a later tick can still re-ready it
                if (in_range)
                    task_state[t] = tdrs_pkg::ST_READY;
            end
            tdrs_pkg::CMD_CREATE:
            begin
                if (in_range)
                begin
                    tick_left[t]  = '0;
                    task_state[t] = tdrs_pkg::ST_READY;
                end
            end
            tdrs_pkg::CMD_SCHED:
            begin
                for (int i = 0; i < tdrs_pkg::TASK_COUNT; i++)
                begin
                    if (!r.hit && task_state[i] == tdrs_pkg::ST_READY)
                    begin
                        task_state[i] = tdrs_pkg::ST_ACTIVE;
                        r.sel         = tdrs_pkg::SEL_OUT_W'(i);
                        r.hit         = 1'b1;
                    end
                end
            end
            default:
            begin
                // spare codes: no state change, idle result
            end
        endcase
        return r;
    endfunction

    // Monitor at the rising edge: check a taken result word against the
    // oldest prediction, then predict for a taken command word. Results are
    // registered, so a word taken now never answers at this same edge.
    always @(posedge clk)
    begin
        pick_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_picks.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (pending_picks.size() == 0)
                begin
                    $error("result word with nothing expected: selected_task %0d found %0d",
                           selected_task, found);
                    err_count++;
                end
                else
                begin
                    want = pending_picks.pop_front();
                    if (selected_task !== want.sel)
                    begin
                        $error("selected_task: expected %0d, got %0d", want.sel, selected_task);
                        err_count++;
                    end
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0d, got %0d", want.hit, found);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = predict_command(command, task_req, delay_ms);
                pending_picks.push_back(want);
                words_in++;
                cmd_seen[command]++;
                if (want.hit)
                    picks_found++;
            end
        end
    end

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one command word, with random idle cycles ahead of it. Called and
    // returns at a falling edge; valid stays high so back-to-back words flow.
    task automatic send_word(input logic [tdrs_pkg::CMD_W-1:0] c,
                             input logic [tdrs_pkg::REQ_W-1:0] t,
                             input logic [tdrs_pkg::DLY_W-1:0] d);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = c;
        task_req = t;
        delay_ms = d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pauses until every owed result is back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random word: short delays dominate so waiting tasks actually expire,
    // schedule is frequent so ready tasks get picked and the chain is exercised.
    task automatic send_random_word();
        int unsigned                roll;
        logic [tdrs_pkg::CMD_W-1:0] c;
        logic [tdrs_pkg::DLY_W-1:0] d;
        roll = $urandom_range(99);
        if (roll < 30)
            c = tdrs_pkg::CMD_TICK;
        else if (roll < 50)
            c = tdrs_pkg::CMD_DELAY;
        else if (roll < 60)
            c = tdrs_pkg::CMD_READY;
        else if (roll < 70)
            c = tdrs_pkg::CMD_CREATE;
        else if (roll < 95)
            c = tdrs_pkg::CMD_SCHED;
        else
            c = tdrs_pkg::CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        roll = $urandom_range(9);
        if (roll < 6)
            d = tdrs_pkg::DLY_W'($urandom_range(6));
        else if (roll < 8)
            d = tdrs_pkg::DLY_W'($urandom);
        else if (roll == 8)
            d = '0;
        else
            d = DLY_MAX;
        send_word(c, tdrs_pkg::REQ_W'($urandom), d);
    endtask

    // Corners: empty schedule, first/last task, zero delay, ready keeping a
    // counter, tick re-readying a task that is not waiting, create clearing
    // a counter, spare codes.
    task automatic test_directed_cases();
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // nothing ready: idle
        send_word(tdrs_pkg::CMD_CREATE, 3'd0, DLY_MAX);
        send_word(tdrs_pkg::CMD_CREATE, 3'd7, '0);
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // picks 0
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // picks 7
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // idle again
        send_word(tdrs_pkg::CMD_DELAY,  3'd3, '0);        // waits with zero counter
        send_word(tdrs_pkg::CMD_TICK,   3'd0, '0);
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // 3 still waiting
        send_word(tdrs_pkg::CMD_READY,  3'd3, '0);
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // picks 3
        send_word(tdrs_pkg::CMD_DELAY,  3'd5, 16'd1);
        send_word(tdrs_pkg::CMD_TICK,   3'd0, '0);        // 5 expires
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);
        send_word(tdrs_pkg::CMD_DELAY,  3'd2, DLY_MAX);
        send_word(tdrs_pkg::CMD_READY,  3'd2, '0);        // counter kept
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // 2 active, still counting
        send_word(tdrs_pkg::CMD_DELAY,  3'd4, 16'd2);
        send_word(tdrs_pkg::CMD_READY,  3'd4, '0);
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // 4 active
        send_word(tdrs_pkg::CMD_TICK,   3'd0, '0);
        send_word(tdrs_pkg::CMD_TICK,   3'd0, '0);        // 4 re-readied from active
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);
        send_word(tdrs_pkg::CMD_DELAY,  3'd1, 16'd3);
        send_word(tdrs_pkg::CMD_CREATE, 3'd1, '0);        // counter cleared
        send_word(tdrs_pkg::CMD_TICK,   3'd0, '0);
        send_word(tdrs_pkg::CMD_SCHED,  3'd0, '0);        // picks 1 via create
        send_word(CMD_SPARE_FIRST, 3'd7, DLY_MAX);
        send_word(CMD_SPARE_LAST,  3'd0, 16'h5A5A);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n, input int unsigned gap_pct,
                                       input int unsigned stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_word();
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // words back to back: the result register fills and in_stall must hold.
    task automatic test_output_hold();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        in_valid       = 1'b0;
        @(posedge clk);
        hold_req = 300;
        @(negedge clk);
        repeat (40) send_random_word();
        wait_drained();
    endtask

    // After a full pause, schedule everything left to confirm state held.
    task automatic test_quiet_restart();
        repeat (tdrs_pkg::TASK_COUNT + 1) send_word(tdrs_pkg::CMD_SCHED, '0, '0);
        wait_drained();
    endtask

    initial
    begin
        int unsigned spare_seen;
        spare_seen = 0;
        for (int i = 0; i < tdrs_pkg::TASK_COUNT; i++)
        begin
            task_state[i] = tdrs_pkg::ST_NONE;
            tick_left[i]  = '0;
        end
        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_gap_pct   = 25;
        recv_stall_pct = 79;
        test_directed_cases();
        test_random_traffic(420, 25, 79);
        test_random_traffic(420, 79, 25);
        test_random_traffic(420, 0, 0);
        test_output_hold();
        test_quiet_restart();

        if (pending_picks.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_picks.size());
            err_count++;
        end
        for (int k = int'(CMD_SPARE_FIRST); k <= int'(CMD_SPARE_LAST); k++)
            spare_seen += cmd_seen[k];
        $display("Run covered %0d command words and %0d result words, %0d errors",
                 words_in, words_out, err_count);
        $display("Per command: tick %0d delay %0d ready %0d create %0d schedule %0d",
                 cmd_seen[tdrs_pkg::CMD_TICK], cmd_seen[tdrs_pkg::CMD_DELAY],
                 cmd_seen[tdrs_pkg::CMD_READY], cmd_seen[tdrs_pkg::CMD_CREATE],
                 cmd_seen[tdrs_pkg::CMD_SCHED]);
        $display("Spare codes %0d, tasks picked %0d", spare_seen, picks_found);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
